// File: rtl/hmc_pkg.sv
// Shared types, constants and position helpers for the Hamming codec.
package hmc_pkg;

    localparam int WORD_W       = 63;
    localparam int LEN_W        = 6;
    localparam int PAR_W        = 3;
    localparam int NUM_PAR      = 6;
    localparam int NUM_DATA_POS = 57;   // non-power-of-two positions in 1..63
    localparam int CFG_DATA_W   = 6;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 72;

    typedef enum logic [1:0] {
        OP_ENCODE     = 2'd0,
        OP_DECODE     = 2'd1,
        OP_DECODE_FIX = 2'd2,
        OP_CHECK      = 2'd3
    } t_op;

    typedef enum logic {
        REG_CODE_LENGTH  = 1'b0,
        REG_PARITY_COUNT = 1'b1
    } t_reg_idx;

    // bit b covers code position b+1; set i holds the positions with index bit i set
    localparam logic [63:0] PARITY_SETS [NUM_PAR] = '{
        64'h5555555555555555,
        64'h6666666666666666,
        64'h7878787878787878,
        64'h7F807F807F807F80,
        64'h7FFF80007FFF8000,
        64'h7FFFFFFF80000000
    };

    typedef struct packed {
        logic [LEN_W-1:0] code_length;
        logic [PAR_W-1:0] parity_count;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic [LEN_W-1:0]  syndrome;
        logic              corrupted;
    } t_result;

    // 1-based code position that carries data bit d
    function automatic int data_pos(input int d);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (cnt == d) pos = p;
                cnt++;
            end
        end
        return pos;
    endfunction

endpackage

// File: rtl/hamming_codec.sv
// Hamming codec top level: input register, codec logic, result register.
// A word accepted on s_axis is held in the input register, then in the result register, which drives m_axis.
// Throughput: one word per cycle; under an m_axis stall one more word enters the
// input stage, then s_axis_tready drops until the result register drains.
// Reset (synchronous, active low) empties both stages and sets code_length 7,
// parity_count 3.
module hamming_codec
    import hmc_pkg::*;
#(
    parameter int MAX_CODE_BITS = 63
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // operation[1:0], word[64:2], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // result_word[62:0], syndrome[68:63],
                                                  // corrupted[69], zero pad
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_op               r_in_op;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              w_out_free;
    logic              w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_length  <= LEN_W'(7);
            r_cfg.parity_count <= PAR_W'(3);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_CODE_LENGTH:  r_cfg.code_length  <= i_cfg_wdata[LEN_W-1:0];
                REG_PARITY_COUNT: r_cfg.parity_count <= i_cfg_wdata[PAR_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_adv      = !r_in_valid || w_out_free;
    assign s_axis_tready = w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_adv) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_in_adv) begin
            r_in_op   <= t_op'(s_axis_tdata[1:0]);
            r_in_word <= s_axis_tdata[WORD_W+1:2];
        end
    end

    hmc_core #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_core (
        .i_cfg    (r_cfg),
        .i_op     (r_in_op),
        .i_word   (r_in_word),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_out_free) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.corrupted, r_out.syndrome, r_out.result_word};

`ifndef ASSERT_OFF
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");

    a_word_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free) |=> r_out_valid)
        else $error("word in input stage lost on its way to the result register");

    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.corrupted == (r_out.syndrome != '0)))
        else $error("corrupted flag disagrees with syndrome");
`endif

endmodule

// File: rtl/hmc_core.sv
// Combinational Hamming encode, decode, correct and syndrome logic for one word.
module hmc_core
    import hmc_pkg::*;
#(
    parameter int MAX_CODE_BITS = 63
)(
    input  t_cfg              i_cfg,
    input  t_op               i_op,
    input  logic [WORD_W-1:0] i_word,
    output t_result           o_result
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

    logic [LEN_W-1:0]  n_eff;
    logic [PAR_W-1:0]  m_eff;
    logic [WORD_W-1:0] len_mask;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] scatter;
    logic [WORD_W-1:0] sc_masked;
    logic [WORD_W-1:0] enc;
    logic [WORD_W-1:0] flip;
    logic [WORD_W-1:0] fixed;
    logic [WORD_W-1:0] gather;
    logic [LEN_W-1:0]  syn;

    assign n_eff = (i_cfg.code_length > MAX_LEN) ? MAX_LEN : i_cfg.code_length;
    assign m_eff = (i_cfg.parity_count > PAR_W'(NUM_PAR)) ? PAR_W'(NUM_PAR)
                                                          : i_cfg.parity_count;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            len_mask[b] = (LEN_W'(b) < n_eff);
        end
    end

    assign w = i_word & len_mask;

    // fixed wiring between data bit order and code positions
    genvar d, j;
    generate
        for (d = 0; d < NUM_DATA_POS; d++) begin : g_map
            localparam int POS = data_pos(d);
            assign scatter[POS-1] = w[d];
            assign gather[d]      = fixed[POS-1];
        end
        for (j = 0; j < NUM_PAR; j++) begin : g_par_slot
            assign scatter[(1 << j) - 1] = 1'b0;
        end
    endgenerate

    assign gather[WORD_W-1:NUM_DATA_POS] = '0;
    assign sc_masked = scatter & len_mask;

    always_comb begin
        for (int i = 0; i < NUM_PAR; i++) begin
            syn[i] = (PAR_W'(i) < m_eff) & (^(w & PARITY_SETS[i][WORD_W-1:0]));
        end
    end

    // parity slots are empty in sc_masked, so each parity bit is independent
    always_comb begin
        enc = sc_masked;
        for (int i = 0; i < NUM_PAR; i++) begin
            if ((PAR_W'(i) < m_eff) && (LEN_W'(1 << i) <= n_eff)) begin
                enc[(1 << i) - 1] = ^(sc_masked & PARITY_SETS[i][WORD_W-1:0]);
            end
        end
    end

    always_comb begin
        flip = '0;
        if ((i_op == OP_DECODE_FIX) && (syn != '0) && (syn <= n_eff)) begin
            flip[syn - 1'b1] = 1'b1;
        end
    end

    assign fixed = w ^ flip;

    always_comb begin
        o_result.syndrome  = syn;
        o_result.corrupted = (syn != '0);
        case (i_op) inside
            OP_ENCODE:                o_result.result_word = enc;
            OP_DECODE, OP_DECODE_FIX: o_result.result_word = gather;
            default:                  o_result.result_word = '0;
        endcase
    end

endmodule
